[rtl/button_debounce_long_press_macros.svh]
// Assertion macros for the button debouncer.
// Used by the top level; expects clk and rst_n in the including scope.
`ifndef BUTTON_DEBOUNCE_LONG_PRESS_MACROS_SVH
`define BUTTON_DEBOUNCE_LONG_PRESS_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define BDLP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while in reset
`define BDLP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/bdlp_pkg.sv]
// Shared types and constants for the button debouncer.
// No dependencies; imported by every module of the block.
package bdlp_pkg;

  localparam int BUTTON_COUNT_DEF = 5;
  localparam int PIN_W            = 5;
  localparam int TS_W             = 32;
  localparam int CFG_W            = 16;
  localparam int EVT_W            = 3;
  localparam int ADDR_W           = 3;
  localparam int DATA_W           = 32;

  localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd30;
  localparam logic [CFG_W-1:0] LONG_RST     = 16'd2000;

  // Register index, taken from paddr[2]
  localparam logic REG_DEBOUNCE = 1'b0;
  localparam logic REG_LONG     = 1'b1;

  // Event codes
  localparam logic [EVT_W-1:0] EVT_NONE = 3'd0;
  localparam logic [EVT_W-1:0] EVT_HOME = 3'd1;

  typedef struct packed {
    logic [TS_W-1:0]  now_ms;
    logic [PIN_W-1:0] pin_levels;
  } in_item_t;

  typedef struct packed {
    logic [EVT_W-1:0] event_button;
    logic             is_long;
  } out_item_t;

  // Per-button findings for one poll
  typedef struct packed {
    logic short_ev;
    logic long_ev;
  } lane_evt_t;

endpackage

[rtl/bdlp_lane.sv]
// One button lane: raw/stable tracking, press timing and long-press flag.
// Depends on bdlp_pkg.
module bdlp_lane #(
  parameter bit LONG_EN = 1'b0
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        adv,
  input  logic [bdlp_pkg::TS_W-1:0]   now_ms,
  input  logic                        pressed,
  input  logic [bdlp_pkg::CFG_W-1:0]  debounce_time,
  input  logic [bdlp_pkg::CFG_W-1:0]  long_press_time,
  output bdlp_pkg::lane_evt_t         evt
);
  import bdlp_pkg::*;

  logic            raw_r, raw_nxt;
  logic            stable_r, stable_nxt;
  logic            long_r, long_nxt;
  logic [TS_W-1:0] change_r, change_nxt;
  logic [TS_W-1:0] start_r, start_nxt;

  logic            raw_chg;
  logic [TS_W-1:0] since_chg;
  logic [TS_W-1:0] since_press;
  logic            deb_ok;
  logic            flip;
  logic            go_press;
  logic            go_release;
  logic            hold_ok;
  logic            long_base;
  logic            long_hit;

  // Elapsed times against the stored marks; a fresh mark means zero elapsed
  always_comb begin
    raw_chg     = pressed != raw_r;
    since_chg   = now_ms - change_r;
    since_press = now_ms - start_r;
    deb_ok      = raw_chg ? (debounce_time == '0)
                          : (since_chg >= {{(TS_W-CFG_W){1'b0}}, debounce_time});
    flip        = deb_ok && (stable_r != pressed);
    go_press    = flip && pressed;
    go_release  = flip && !pressed;
    hold_ok     = go_press ? (long_press_time == '0)
                           : (since_press >= {{(TS_W-CFG_W){1'b0}}, long_press_time});
  end

  // Next state and events
  always_comb begin
    raw_nxt      = pressed;
    change_nxt   = raw_chg ? now_ms : change_r;
    stable_nxt   = flip ? pressed : stable_r;
    start_nxt    = go_press ? now_ms : start_r;
    long_base    = go_press ? 1'b0 : long_r;
    long_hit     = LONG_EN && stable_nxt && !long_base && hold_ok;
    long_nxt     = long_hit | long_base;
    evt.short_ev = go_release && !long_r;
    evt.long_ev  = long_hit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_r    <= 1'b0;
      stable_r <= 1'b0;
      long_r   <= 1'b0;
      change_r <= '0;
      start_r  <= '0;
    end else if (adv) begin
      raw_r    <= raw_nxt;
      stable_r <= stable_nxt;
      long_r   <= long_nxt;
      change_r <= change_nxt;
      start_r  <= start_nxt;
    end
  end

endmodule

[rtl/bdlp_merge.sv]
// Priority merge of the lane events: lowest button index wins.
// Depends on bdlp_pkg.
module bdlp_merge #(
  parameter int BUTTON_COUNT = bdlp_pkg::BUTTON_COUNT_DEF
) (
  input  bdlp_pkg::lane_evt_t evt [BUTTON_COUNT],
  output bdlp_pkg::out_item_t item
);
  import bdlp_pkg::*;

  // Scan from the top down so the lowest qualifying lane is assigned last
  always_comb begin
    item.event_button = EVT_NONE;
    item.is_long      = 1'b0;
    for (int i = BUTTON_COUNT - 1; i >= 0; i--) begin
      if (evt[i].short_ev || evt[i].long_ev) begin
        item.event_button = EVT_W'(i + 1);
        item.is_long      = evt[i].long_ev;
      end
    end
  end

endmodule

[rtl/button_debounce_long_press.sv]
// Button debouncer with short and long press detection, one lane per button.
// The result is registered: it is valid in the cycle after the poll is accepted.
// Throughput: one poll per cycle; in_ready stays high while the result register
// is empty or being drained, so polls stream back to back.
// Reset (rst_n low, synchronous): all button state cleared, registers to 30/2000.
// Depends on bdlp_pkg, bdlp_lane, bdlp_merge and the macros header.
`include "button_debounce_long_press_macros.svh"

module button_debounce_long_press #(
  parameter int BUTTON_COUNT = bdlp_pkg::BUTTON_COUNT_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // poll channel
  input  logic                         in_valid,
  output logic                         in_ready,
  input  bdlp_pkg::in_item_t           in_data,
  // result channel
  output logic                         out_valid,
  input  logic                         out_ready,
  output bdlp_pkg::out_item_t          out_data,
  // register port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bdlp_pkg::ADDR_W-1:0]  paddr,
  input  logic [bdlp_pkg::DATA_W-1:0]  pwdata,
  output logic [bdlp_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);
  import bdlp_pkg::*;

  logic [CFG_W-1:0] debounce_r;
  logic [CFG_W-1:0] long_time_r;
  logic             out_valid_r;
  out_item_t        out_r;
  out_item_t        merged;
  lane_evt_t        evt [BUTTON_COUNT];
  logic             in_acc;
  logic             wr_en;
  logic             out_long;
  logic             out_none;

  // Register port
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r  <= DEBOUNCE_RST;
      long_time_r <= LONG_RST;
    end else if (wr_en) begin
      case (paddr[2])
        REG_DEBOUNCE: debounce_r  <= pwdata[CFG_W-1:0];
        REG_LONG:     long_time_r <= pwdata[CFG_W-1:0];
        default:      debounce_r  <= debounce_r;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_DEBOUNCE: prdata = {{(DATA_W-CFG_W){1'b0}}, debounce_r};
      REG_LONG:     prdata = {{(DATA_W-CFG_W){1'b0}}, long_time_r};
      default:      prdata = '0;
    endcase
  end

  // Handshake: result register drains while the next poll enters
  assign in_ready = !out_valid_r || out_ready;
  assign in_acc   = in_valid && in_ready;

  // Button lanes; buttons past the pin field read as pressed
  for (genvar g = 0; g < BUTTON_COUNT; g++) begin : g_lane
    logic pressed;
    if (g < PIN_W) begin : g_pin
      assign pressed = !in_data.pin_levels[g];
    end else begin : g_nopin
      assign pressed = 1'b1;
    end

    bdlp_lane #(
      .LONG_EN (g == 0)
    ) u_lane (
      .clk             (clk),
      .rst_n           (rst_n),
      .adv             (in_acc),
      .now_ms          (in_data.now_ms),
      .pressed         (pressed),
      .debounce_time   (debounce_r),
      .long_press_time (long_time_r),
      .evt             (evt[g])
    );
  end

  bdlp_merge #(
    .BUTTON_COUNT (BUTTON_COUNT)
  ) u_merge (
    .evt  (evt),
    .item (merged)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_r <= merged;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Checks
  assign out_long = out_valid && out_data.is_long;
  assign out_none = out_valid && (out_data.event_button == EVT_NONE);

  `BDLP_ASSERT_NXT(a_acc_gives_result, in_acc, out_valid, "accepted poll produced no result")
  `BDLP_ASSERT_IMP(a_long_is_home, out_long, out_data.event_button == EVT_HOME, "long not home")
  `BDLP_ASSERT_IMP(a_none_not_long, out_none, !out_data.is_long, "long flag without an event")

endmodule
